// ===== src/mlfba_pkg.sv =====
// shared types and constants of the multi-level flash block allocator
package mlfba_pkg;

	localparam int NUM_BLOCKS  = 1024;
	localparam int MAX_PAGES   = 256;
	localparam int LEVELS      = 4;
	localparam int BPL         = NUM_BLOCKS / LEVELS;
	localparam int BLK_W       = 10;
	localparam int LV_W        = 2;
	localparam int POS_W       = 8;
	localparam int CUR_W       = 9;
	localparam int CNT_W       = 16;
	localparam int GC_BIG_LIST = 100;
	localparam int GC_MIN_FREE = 2;
	localparam int GC_LIMIT    = (BPL < GC_BIG_LIST) ? GC_MIN_FREE
		: (BPL / GC_BIG_LIST + GC_MIN_FREE);

	localparam logic [CNT_W-1:0] CNT_MAX   = '1;
	localparam logic [8:0]       ERASE_MAX = 9'd511;

	typedef enum logic [2:0] {
		K_ALLOC        = 3'd0,
		K_INVAL        = 3'd1,
		K_RD_ISSUE     = 3'd2,
		K_RD_DONE      = 3'd3,
		K_PGM_DONE     = 3'd4,
		K_ERASE_START  = 3'd5,
		K_ERASE_FINISH = 3'd6,
		K_QUERY        = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		BS_IDLE    = 2'd0,
		BS_WORKING = 2'd1,
		BS_ERASING = 2'd2
	} blk_status_t;

	typedef struct packed {
		blk_status_t      status;
		logic [8:0]       pcur;
		logic [8:0]       icnt;
		logic [CNT_W-1:0] rd;
		logic [CNT_W-1:0] pgm;
		logic [31:0]      ctime;
	} blk_rec_t;

	typedef struct packed {
		logic [BLK_W-1:0] alloc_block;
		logic [7:0]       alloc_page;
		logic             gc_request;
		logic             page_valid;
		logic [31:0]      block_age;
		logic [8:0]       invalid_pages;
		logic             error;
	} res_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_REC_RD,
		S_EXEC,
		S_A_ORD,
		S_A_REC,
		S_A_UPD,
		S_A_SCAN,
		S_A_SREC,
		S_A_SCHK,
		S_A_GC,
		S_A_NORD,
		S_A_NREC,
		S_A_NUPD,
		S_E_SCAN,
		S_E_CMP,
		S_E_SHRD,
		S_E_SHWR,
		S_DONE
	} fsm_t;

endpackage

// ===== src/mlfba_ram.sv =====
// generic single write port ram with registered read
module mlfba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/multi_level_flash_block_allocator_top.sv =====
// top level of the multi-level flash block allocator
//
// channel  | handshake          | payload
// config   | psel/penable/pready| paddr, pwdata, prdata (pages_per_block at 0)
// input    | in_valid/in_stall  | kind, level, for_read, page_address, block_id,
//          |                    | page_in_block, now_time
// output   | out_valid/out_stall| alloc_block, alloc_page, gc_request, writes_stopped,
//          |                    | page_valid, block_age, invalid_pages, error
//
// after reset a clearing pass fills the block, bitmap and order rams
// one item at a time: allocate reads the order ram and the block record and writes
// it back, a refused one goes straight out, and a block fill adds a scan past busy
// blocks; other kinds go through the 18-step shared divider or straight to the record
// erase finish adds a list search and a list shift
// in_stall is high while an item is at work or the clearing pass runs
module multi_level_flash_block_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [1:0]  level,
	input  logic        for_read,
	input  logic [17:0] page_address,
	input  logic [9:0]  block_id,
	input  logic [7:0]  page_in_block,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  alloc_block,
	output logic [7:0]  alloc_page,
	output logic        gc_request,
	output logic        writes_stopped,
	output logic        page_valid,
	output logic [31:0] block_age,
	output logic [8:0]  invalid_pages,
	output logic        error
);
	import mlfba_pkg::*;

	localparam int REC_W = $bits(blk_rec_t);

	fsm_t             state_q, state_d;
	logic [BLK_W-1:0] clr_q;
	logic [8:0]       ppb_q;
	logic [CUR_W-1:0] cur_q [LEVELS];
	logic [8:0]       ec_q [LEVELS];
	kind_t            kind_q;
	logic [LV_W-1:0]  lv_q;
	logic             for_read_q;
	logic [31:0]      now_q;
	logic [7:0]       pib_q;
	logic [BLK_W-1:0] blk_q;
	logic [BLK_W-1:0] nb_q;
	logic [8:0]       pg_q;
	logic [POS_W-1:0] pos_q;
	res_t             res_q;
	logic             ws_q;
	logic             out_valid_q;
	res_t             out_q;
	logic [17:0]      dvd_q;
	logic [17:0]      quo_q;
	logic [8:0]       rem_q;
	logic [4:0]       div_cnt_q;

	logic             rec_we, bmp_we, ord_we;
	logic [BLK_W-1:0] rec_waddr, rec_raddr, ord_waddr, ord_raddr;
	blk_rec_t         rec_wdata, rec_rdata;
	logic [REC_W-1:0] rec_rdata_raw;
	logic [MAX_PAGES-1:0] bmp_wdata, bmp_rdata;
	logic [BLK_W-1:0] ord_wdata, ord_rdata;

	logic [8:0]       ppb_eff;
	logic [LV_W-1:0]  lvb;
	logic [CUR_W-1:0] cur_lv, cur_b;
	logic             cfg_wr, accept, out_free;
	logic             acc_err;
	res_t             res_init;
	logic [9:0]       trial;
	logic             trial_ge;
	logic [8:0]       rem_n;
	logic [17:0]      quo_n;
	logic             a_full, a_filled, over_gc;
	blk_rec_t         a_new, e_new;
	logic             e_err, e_bit_pg, e_bit_q;
	logic [8:0]       e_inv;

	assign rec_rdata = blk_rec_t'(rec_rdata_raw);

	mlfba_ram #(.WIDTH(REC_W), .DEPTH(NUM_BLOCKS)) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(rec_waddr),
		.wdata(REC_W'(rec_wdata)),
		.raddr(rec_raddr),
		.rdata(rec_rdata_raw)
	);

	mlfba_ram #(.WIDTH(MAX_PAGES), .DEPTH(NUM_BLOCKS)) u_bmp_ram (
		.clk  (clk),
		.we   (bmp_we),
		.waddr(rec_waddr),
		.wdata(bmp_wdata),
		.raddr(blk_q),
		.rdata(bmp_rdata)
	);

	mlfba_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_ord_ram (
		.clk  (clk),
		.we   (ord_we),
		.waddr(ord_waddr),
		.wdata(ord_wdata),
		.raddr(ord_raddr),
		.rdata(ord_rdata)
	);

	assign pready   = 1'b1;
	assign prdata   = {23'd0, ppb_q};
	assign cfg_wr   = psel && penable && pwrite;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// allocate refused at once
	assign acc_err = (kind_t'(kind) == K_ALLOC)
		&& (32'(level) >= LEVELS || cur_q[level] >= CUR_W'(BPL));
	always_comb begin
		res_init       = '0;
		res_init.error = acc_err;
	end

	assign ppb_eff = (ppb_q == 9'd0) ? 9'd1
		: ((ppb_q > 9'(MAX_PAGES)) ? 9'(MAX_PAGES) : ppb_q);
	assign lvb    = LV_W'(blk_q / BPL);
	assign cur_lv = cur_q[lv_q];
	assign cur_b  = cur_q[lvb];

	// restoring divide step
	assign trial    = {rem_q, dvd_q[17]};
	assign trial_ge = trial >= {1'b0, ppb_eff};
	assign rem_n    = trial_ge ? 9'(trial - {1'b0, ppb_eff}) : trial[8:0];
	assign quo_n    = {quo_q[16:0], trial_ge};

	// allocate update of the current block
	assign a_full   = rec_rdata.pcur >= ppb_eff;
	assign a_filled = (rec_rdata.pcur + 9'd1) >= ppb_eff;
	always_comb begin
		a_new = rec_rdata;
		if (rec_rdata.status == BS_IDLE) begin
			a_new.status = BS_WORKING;
			a_new.ctime  = now_q;
		end
		a_new.pcur = rec_rdata.pcur + 9'd1;
		if (!for_read_q && rec_rdata.pgm != CNT_MAX) begin
			a_new.pgm = rec_rdata.pgm + 16'd1;
		end
	end

	// free blocks of the level under the threshold
	assign over_gc = (11'(ec_q[lv_q]) + 11'(BPL)) < (11'(cur_lv) + 11'(GC_LIMIT + 1));

	// per-block kinds
	assign e_bit_pg = bmp_rdata[pg_q[7:0]];
	assign e_bit_q  = bmp_rdata[pib_q];
	always_comb begin
		e_new     = rec_rdata;
		e_err     = 1'b0;
		bmp_wdata = bmp_rdata;
		case (kind_q)
			K_INVAL: begin
				if (!e_bit_pg) begin
					bmp_wdata[pg_q[7:0]] = 1'b1;
					e_new.icnt = rec_rdata.icnt + 9'd1;
				end
			end
			K_RD_ISSUE: begin
				if (rec_rdata.rd != CNT_MAX) begin
					e_new.rd = rec_rdata.rd + 16'd1;
				end
			end
			K_RD_DONE: begin
				if (rec_rdata.rd == '0) begin
					e_err = 1'b1;
				end else begin
					e_new.rd = rec_rdata.rd - 16'd1;
				end
			end
			K_PGM_DONE: begin
				if (rec_rdata.pgm == '0) begin
					e_err = 1'b1;
				end else begin
					e_new.pgm = rec_rdata.pgm - 16'd1;
				end
			end
			K_ERASE_START: begin
				if (rec_rdata.status == BS_ERASING) begin
					e_err = 1'b1;
				end else begin
					e_new.status = BS_ERASING;
				end
			end
			K_ERASE_FINISH: begin
				if (rec_rdata.status != BS_ERASING) begin
					e_err = 1'b1;
				end else begin
					e_new     = '0;
					bmp_wdata = '0;
					if (ec_q[lvb] == 9'd0) begin
						e_err = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_CLEAR) begin
			bmp_wdata = '0;
		end
		e_inv = e_new.icnt;
	end

	// next state and ram ports
	always_comb begin
		state_d   = state_q;
		rec_we    = 1'b0;
		bmp_we    = 1'b0;
		ord_we    = 1'b0;
		rec_waddr = blk_q;
		rec_wdata = a_new;
		rec_raddr = blk_q;
		ord_waddr = {lvb, pos_q};
		ord_wdata = ord_rdata;
		ord_raddr = {lv_q, cur_lv[POS_W-1:0]};
		case (state_q)
			S_CLEAR: begin
				rec_we    = 1'b1;
				bmp_we    = 1'b1;
				ord_we    = 1'b1;
				rec_waddr = clr_q;
				rec_wdata = '0;
				ord_waddr = clr_q;
				ord_wdata = clr_q;
				if (clr_q == BLK_W'(NUM_BLOCKS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					if (kind_t'(kind) == K_ALLOC) begin
						if (acc_err) begin
							state_d = S_DONE;
						end else begin
							state_d = S_A_ORD;
						end
					end else if (kind <= K_PGM_DONE) begin
						state_d = S_DIV;
					end else begin
						state_d = S_REC_RD;
					end
				end
			end
			S_DIV: begin
				if (div_cnt_q == 5'd17) begin
					state_d = (quo_n[17:BLK_W] != '0) ? S_DONE : S_REC_RD;
				end
			end
			S_REC_RD: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				rec_we    = 1'b1;
				rec_wdata = e_new;
				bmp_we    = (kind_q == K_INVAL) || (kind_q == K_ERASE_FINISH);
				if (e_err && kind_q != K_ERASE_FINISH) begin
					rec_we = 1'b0;
					bmp_we = 1'b0;
				end
				if (kind_q == K_ERASE_FINISH && rec_rdata.status != BS_ERASING) begin
					rec_we  = 1'b0;
					bmp_we  = 1'b0;
					state_d = S_DONE;
				end else if (kind_q == K_ERASE_FINISH) begin
					state_d = S_E_SCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_A_ORD: begin
				state_d = S_A_REC;
			end
			S_A_REC: begin
				rec_raddr = ord_rdata;
				state_d   = S_A_UPD;
			end
			S_A_UPD: begin
				if (a_full) begin
					state_d = S_DONE;
				end else begin
					rec_we  = 1'b1;
					state_d = a_filled ? S_A_SCAN : S_DONE;
				end
			end
			S_A_SCAN: begin
				state_d = (cur_lv >= CUR_W'(BPL - 1)) ? S_A_GC : S_A_SREC;
			end
			S_A_SREC: begin
				rec_raddr = ord_rdata;
				state_d   = S_A_SCHK;
			end
			S_A_SCHK: begin
				state_d = (rec_rdata.status == BS_IDLE) ? S_A_GC : S_A_SCAN;
			end
			S_A_GC: begin
				if (over_gc || cur_lv >= CUR_W'(BPL)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_A_NORD;
				end
			end
			S_A_NORD: begin
				state_d = S_A_NREC;
			end
			S_A_NREC: begin
				rec_raddr = ord_rdata;
				state_d   = S_A_NUPD;
			end
			S_A_NUPD: begin
				rec_waddr        = nb_q;
				rec_wdata        = rec_rdata;
				rec_wdata.status = BS_WORKING;
				rec_wdata.ctime  = now_q;
				rec_we           = (rec_rdata.status == BS_IDLE);
				state_d          = S_DONE;
			end
			S_E_SCAN: begin
				ord_raddr = {lvb, pos_q};
				state_d   = S_E_CMP;
			end
			S_E_CMP: begin
				if (ord_rdata == blk_q) begin
					state_d = S_E_SHRD;
				end else if (pos_q == '1) begin
					state_d = S_DONE;
				end else begin
					state_d = S_E_SCAN;
				end
			end
			S_E_SHRD: begin
				ord_raddr = {lvb, POS_W'(pos_q + 1'b1)};
				if (pos_q == '1) begin
					ord_we    = 1'b1;
					ord_wdata = blk_q;
					state_d   = S_DONE;
				end else begin
					state_d = S_E_SHWR;
				end
			end
			S_E_SHWR: begin
				ord_we  = 1'b1;
				state_d = S_E_SHRD;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			ppb_q       <= 9'(MAX_PAGES);
			out_valid_q <= 1'b0;
			for (int i = 0; i < LEVELS; i++) begin
				cur_q[i] <= '0;
				ec_q[i]  <= '0;
			end
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_wr) begin
				ppb_q <= pwdata[8:0];
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_A_UPD: begin
					if (!a_full && a_filled) begin
						cur_q[lv_q] <= cur_lv + 1'b1;
					end
				end
				S_A_SCHK: begin
					if (rec_rdata.status != BS_IDLE) begin
						cur_q[lv_q] <= cur_lv + 1'b1;
					end
				end
				S_EXEC: begin
					if (kind_q == K_ERASE_START && rec_rdata.status != BS_ERASING
						&& ec_q[lvb] != ERASE_MAX) begin
						ec_q[lvb] <= ec_q[lvb] + 1'b1;
					end
					if (kind_q == K_ERASE_FINISH && rec_rdata.status == BS_ERASING
						&& ec_q[lvb] != 9'd0) begin
						ec_q[lvb] <= ec_q[lvb] - 1'b1;
					end
				end
				S_E_CMP: begin
					if (ord_rdata == blk_q && cur_b >= CUR_W'(pos_q) && cur_b != '0) begin
						cur_q[lvb] <= cur_b - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q     <= kind_t'(kind);
					lv_q       <= level;
					for_read_q <= for_read;
					now_q      <= now_time;
					pib_q      <= page_in_block;
					blk_q      <= block_id;
					dvd_q      <= page_address;
					quo_q      <= '0;
					rem_q      <= '0;
					div_cnt_q  <= '0;
					res_q      <= res_init;
				end
			end
			S_DIV: begin
				dvd_q     <= {dvd_q[16:0], 1'b0};
				quo_q     <= quo_n;
				rem_q     <= rem_n;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == 5'd17) begin
					blk_q <= quo_n[BLK_W-1:0];
					pg_q  <= rem_n;
					if (quo_n[17:BLK_W] != '0) begin
						res_q.error <= 1'b1;
					end
				end
			end
			S_EXEC: begin
				res_q.error         <= e_err;
				res_q.invalid_pages <= e_inv;
				if (kind_q == K_QUERY) begin
					res_q.page_valid <= !e_bit_q;
					res_q.block_age  <= now_q - rec_rdata.ctime;
				end
				pos_q <= '0;
			end
			S_A_REC: begin
				blk_q <= ord_rdata;
			end
			S_A_UPD: begin
				if (a_full) begin
					res_q.error <= 1'b1;
				end else begin
					res_q.alloc_block   <= blk_q;
					res_q.alloc_page    <= rec_rdata.pcur[7:0];
					res_q.invalid_pages <= rec_rdata.icnt;
				end
			end
			S_A_SREC, S_A_NREC: begin
				nb_q <= ord_rdata;
			end
			S_A_GC: begin
				if (over_gc) begin
					res_q.gc_request <= 1'b1;
				end
			end
			S_E_CMP: begin
				if (ord_rdata != blk_q) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			S_E_SHWR: begin
				pos_q <= pos_q + 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					out_q <= res_q;
					ws_q  <= (kind_q == K_ALLOC) && !res_q.error
						&& (cur_lv >= CUR_W'(BPL - 1));
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign alloc_block    = out_q.alloc_block;
	assign alloc_page     = out_q.alloc_page;
	assign gc_request     = out_q.gc_request;
	assign writes_stopped = ws_q;
	assign page_valid     = out_q.page_valid;
	assign block_age      = out_q.block_age;
	assign invalid_pages  = out_q.invalid_pages;
	assign error          = out_q.error;

	for (genvar g = 0; g < LEVELS; g++) begin : g_cur_chk
		a_cur_bound: assert property (@(posedge clk) disable iff (!arst_n)
			cur_q[g] <= CUR_W'(BPL))
			else $error("level cursor past list end");
	end

	a_level_list: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_REC |-> LV_W'(ord_rdata / BPL) == lv_q)
		else $error("level list holds a block of another level");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < ppb_eff)
		else $error("divider remainder out of range");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("finished item not presented");
endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the multi-level flash block allocator
module tb_top;
	import mlfba_pkg::*;

	localparam int          CYCLE_LIMIT = 20000000;
	localparam logic [1:0]  REG_PPB     = 2'd0;
	localparam int unsigned PEND_MAX    = 65535;
	localparam int unsigned ERASE_SAT   = 511;

	typedef struct {
		kind_t       kind;
		logic [1:0]  lv;
		logic        fr;
		logic [17:0] addr;
		logic [9:0]  bid;
		logic [7:0]  pib;
		logic [31:0] now;
	} flash_cmd_t;

	typedef struct {
		logic [9:0]  blk;
		logic [7:0]  pg;
		logic        gc;
		logic        ws;
		logic        pv;
		logic [31:0] age;
		logic [8:0]  inv;
		logic        err;
	} flash_res_t;

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [1:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        in_valid, in_stall, out_valid, out_stall;
	logic [2:0]  kind;
	logic [1:0]  level;
	logic        for_read;
	logic [17:0] page_address;
	logic [9:0]  block_id;
	logic [7:0]  page_in_block;
	logic [31:0] now_time;
	logic [9:0]  alloc_block;
	logic [7:0]  alloc_page;
	logic        gc_request, writes_stopped, page_valid, error;
	logic [31:0] block_age;
	logic [8:0]  invalid_pages;

	multi_level_flash_block_allocator_top dut (.*);

	// allocator shadow state
	blk_status_t blk_st[NUM_BLOCKS];
	int unsigned blk_lv[NUM_BLOCKS];
	int unsigned blk_pcur[NUM_BLOCKS];
	int unsigned blk_icnt[NUM_BLOCKS];
	int unsigned blk_rd[NUM_BLOCKS];
	int unsigned blk_pgm[NUM_BLOCKS];
	logic [31:0] blk_ctime[NUM_BLOCKS];
	bit          blk_imap[NUM_BLOCKS][MAX_PAGES];
	int unsigned list_order[NUM_BLOCKS];
	int unsigned lv_cursor[LEVELS];
	int unsigned lv_erasing[LEVELS];
	int unsigned ppb_reg;
	int unsigned erasing_blocks[$];

	flash_res_t  pending_results[$];
	int          fail_count;
	int          cycles;
	int          send_idle_pct, recv_idle_pct;
	logic [31:0] t_now;

	initial begin
		clk = 0;
	end
	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		flash_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				e = pending_results.pop_front();
				if (alloc_block !== e.blk) report("alloc_block", alloc_block, e.blk);
				if (alloc_page !== e.pg) report("alloc_page", alloc_page, e.pg);
				if (gc_request !== e.gc) report("gc_request", gc_request, e.gc);
				if (writes_stopped !== e.ws) report("writes_stopped", writes_stopped, e.ws);
				if (page_valid !== e.pv) report("page_valid", page_valid, e.pv);
				if (block_age !== e.age) report("block_age", block_age, e.age);
				if (invalid_pages !== e.inv) report("invalid_pages", invalid_pages, e.inv);
				if (error !== e.err) report("error", error, e.err);
			end
		end
	end

	function automatic int unsigned eff_pages();
		if (ppb_reg == 0) return 1;
		if (ppb_reg > MAX_PAGES) return MAX_PAGES;
		return ppb_reg;
	endfunction

	function automatic bit level_exhausted(int unsigned lv);
		return lv_cursor[lv] >= BPL - 1;
	endfunction

	function automatic bit below_gc_limit(int unsigned lv);
		int freeb;
		freeb = BPL - (int'(lv_cursor[lv]) + 1) + int'(lv_erasing[lv]);
		return freeb < GC_LIMIT;
	endfunction

	task automatic reset_shadow();
		ppb_reg = 256;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			blk_st[i] = BS_IDLE;
			blk_lv[i] = (i / BPL >= LEVELS) ? LEVELS - 1 : i / BPL;
			blk_pcur[i] = 0;
			blk_icnt[i] = 0;
			blk_rd[i] = 0;
			blk_pgm[i] = 0;
			blk_ctime[i] = 0;
			list_order[i] = i;
			for (int p = 0; p < MAX_PAGES; p++) blk_imap[i][p] = 0;
		end
		for (int l = 0; l < LEVELS; l++) begin
			lv_cursor[l] = 0;
			lv_erasing[l] = 0;
		end
	endtask

	function automatic flash_res_t alloc_page_for(int unsigned lv, bit fr, logic [31:0] now);
		flash_res_t r;
		int unsigned ppb, b, nb;
		r = '{default: '0};
		ppb = eff_pages();
		if (lv_cursor[lv] >= BPL) begin
			r.err = 1;
			return r;
		end
		b = list_order[lv * BPL + lv_cursor[lv]];
		if (blk_pcur[b] >= ppb) begin
			r.err = 1;
			return r;
		end
		if (blk_st[b] == BS_IDLE) begin
			blk_st[b] = BS_WORKING;
			blk_ctime[b] = now;
		end
		r.pg = blk_pcur[b];
		blk_pcur[b]++;
		if (!fr && blk_pgm[b] < PEND_MAX) blk_pgm[b]++;
		if (blk_pcur[b] >= ppb) begin
			lv_cursor[lv]++;
			while (!level_exhausted(lv)) begin
				nb = list_order[lv * BPL + lv_cursor[lv]];
				if (blk_st[nb] == BS_IDLE) break;
				lv_cursor[lv]++;
			end
			if (below_gc_limit(lv)) begin
				r.gc = 1;
			end else if (lv_cursor[lv] < BPL) begin
				nb = list_order[lv * BPL + lv_cursor[lv]];
				if (blk_st[nb] == BS_IDLE) begin
					blk_st[nb] = BS_WORKING;
					blk_ctime[nb] = now;
				end
			end
		end
		r.blk = b;
		r.ws = level_exhausted(lv);
		r.inv = blk_icnt[b];
		return r;
	endfunction

	function automatic bit finish_erase(int unsigned b);
		int unsigned lv, base;
		bit err;
		lv = blk_lv[b];
		err = 0;
		blk_st[b] = BS_IDLE;
		blk_ctime[b] = 0;
		blk_pcur[b] = 0;
		blk_icnt[b] = 0;
		blk_rd[b] = 0;
		blk_pgm[b] = 0;
		for (int p = 0; p < MAX_PAGES; p++) blk_imap[b][p] = 0;
		if (lv_erasing[lv] > 0) lv_erasing[lv]--;
		else err = 1;
		base = lv * BPL;
		for (int p = 0; p < BPL; p++) begin
			if (list_order[base + p] == b) begin
				for (int i = p; i + 1 < BPL; i++) list_order[base + i] = list_order[base + i + 1];
				list_order[base + BPL - 1] = b;
				if (lv_cursor[lv] >= p && lv_cursor[lv] > 0) lv_cursor[lv]--;
				break;
			end
		end
		for (int i = 0; i < erasing_blocks.size(); i++) begin
			if (erasing_blocks[i] == b) begin
				erasing_blocks.delete(i);
				break;
			end
		end
		return err;
	endfunction

	function automatic flash_res_t predict_flash_cmd(flash_cmd_t c);
		flash_res_t r;
		int unsigned ppb, b, pg;
		r = '{default: '0};
		if (c.kind == K_ALLOC) return alloc_page_for(c.lv, c.fr, c.now);
		ppb = eff_pages();
		b = (c.kind <= K_PGM_DONE) ? c.addr / ppb : c.bid;
		pg = c.addr % ppb;
		if (b >= NUM_BLOCKS) begin
			r.err = 1;
			return r;
		end
		case (c.kind)
			K_INVAL: begin
				if (!blk_imap[b][pg]) begin
					blk_imap[b][pg] = 1;
					blk_icnt[b]++;
				end
			end
			K_RD_ISSUE: if (blk_rd[b] < PEND_MAX) blk_rd[b]++;
			K_RD_DONE: begin
				if (blk_rd[b] == 0) r.err = 1;
				else blk_rd[b]--;
			end
			K_PGM_DONE: begin
				if (blk_pgm[b] == 0) r.err = 1;
				else blk_pgm[b]--;
			end
			K_ERASE_START: begin
				if (blk_st[b] == BS_ERASING) begin
					r.err = 1;
				end else begin
					blk_st[b] = BS_ERASING;
					if (lv_erasing[blk_lv[b]] < ERASE_SAT) lv_erasing[blk_lv[b]]++;
					erasing_blocks = {erasing_blocks, b};
				end
			end
			K_ERASE_FINISH: begin
				if (blk_st[b] != BS_ERASING) r.err = 1;
				else r.err = finish_erase(b);
			end
			default: begin
				r.pv = !blk_imap[b][c.pib];
				r.age = c.now - blk_ctime[b];
			end
		endcase
		r.inv = blk_icnt[b];
		return r;
	endfunction

	task automatic send_cmd(flash_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= c.kind;
		level <= c.lv;
		for_read <= c.fr;
		page_address <= c.addr;
		block_id <= c.bid;
		page_in_block <= c.pib;
		now_time <= c.now;
		do @(posedge clk); while (in_stall);
		pending_results = {pending_results, predict_flash_cmd(c)};
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_ppb(int unsigned value);
		drain();
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= REG_PPB;
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		ppb_reg = value & 9'h1FF;
		psel <= 1;
		penable <= 0;
		pwrite <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		if (prdata[8:0] !== ppb_reg[8:0]) report("pages_per_block readback", prdata, ppb_reg);
		psel <= 0;
		penable <= 0;
	endtask

	function automatic flash_cmd_t make_cmd(kind_t k, int unsigned lv, bit fr,
			int unsigned addr, int unsigned bid, int unsigned pib, logic [31:0] now);
		flash_cmd_t c;
		c.kind = k;
		c.lv = lv;
		c.fr = fr;
		c.addr = addr;
		c.bid = bid;
		c.pib = pib;
		c.now = now;
		return c;
	endfunction

	function automatic flash_cmd_t random_cmd(int alloc_pct, int unsigned hot_lv);
		flash_cmd_t c;
		int unsigned ppb, b, l, pos, w;
		ppb = eff_pages();
		w = $urandom_range(99);
		if (w < alloc_pct) c.kind = K_ALLOC;
		else c.kind = kind_t'($urandom_range(7, 1));
		c.lv = ($urandom_range(99) < 80) ? hot_lv : $urandom_range(3);
		c.fr = $urandom_range(1);
		if ($urandom_range(99) < 75) begin
			l = $urandom_range(3);
			pos = (lv_cursor[l] >= BPL) ? BPL - 1 : lv_cursor[l];
			pos = pos - $urandom_range(pos < 3 ? pos : 3);
			b = list_order[l * BPL + pos];
		end else begin
			b = $urandom_range(NUM_BLOCKS - 1);
		end
		if (c.kind == K_ERASE_FINISH && erasing_blocks.size() != 0 && $urandom_range(99) < 75)
			b = erasing_blocks[$urandom_range(erasing_blocks.size() - 1)];
		c.addr = b * ppb + $urandom_range(ppb - 1);
		if ($urandom_range(99) < 10) c.addr = $urandom;
		c.bid = b;
		c.pib = ($urandom_range(1)) ? $urandom_range(255) : $urandom_range(ppb - 1);
		t_now = ($urandom_range(99) < 5) ? $urandom : t_now + $urandom_range(1000);
		c.now = t_now;
		return c;
	endfunction

	task automatic run_random(int n, int alloc_pct);
		int unsigned hot;
		hot = $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			if (i % 80 == 79) hot = $urandom_range(3);
			send_cmd(random_cmd(alloc_pct, hot));
		end
	endtask

	task automatic test_directed();
		write_ppb(256);
		send_cmd(make_cmd(K_ALLOC, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		send_cmd(make_cmd(K_ALLOC, 1, 1, 0, 0, 0, 32'h0));
		send_cmd(make_cmd(K_ALLOC, 2, 0, 0, 0, 0, 32'h8000_0000));
		send_cmd(make_cmd(K_ALLOC, 3, 1, 0, 0, 0, 32'h1234_5678));
		send_cmd(make_cmd(K_INVAL, 0, 0, 1, 0, 0, 0));
		send_cmd(make_cmd(K_INVAL, 0, 0, 1, 0, 0, 0));
		send_cmd(make_cmd(K_INVAL, 0, 0, 18'h3FFFF, 0, 0, 0));
		send_cmd(make_cmd(K_QUERY, 0, 0, 0, 0, 1, 32'h5));
		send_cmd(make_cmd(K_QUERY, 0, 0, 0, 1023, 255, 32'h0));
		send_cmd(make_cmd(K_QUERY, 0, 0, 0, 0, 0, 32'h0));
		send_cmd(make_cmd(K_RD_DONE, 0, 0, 300, 0, 0, 0));
		send_cmd(make_cmd(K_RD_ISSUE, 0, 0, 300, 0, 0, 0));
		send_cmd(make_cmd(K_RD_DONE, 0, 0, 300, 0, 0, 0));
		send_cmd(make_cmd(K_PGM_DONE, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(K_PGM_DONE, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(K_PGM_DONE, 0, 0, 256, 0, 0, 0));
		send_cmd(make_cmd(K_ERASE_FINISH, 0, 0, 0, 5, 0, 0));
		send_cmd(make_cmd(K_ERASE_START, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(K_ERASE_START, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(K_ERASE_FINISH, 0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(K_ALLOC, 0, 0, 0, 0, 0, 32'h77));
		send_cmd(make_cmd(K_ERASE_START, 0, 0, 0, 1023, 0, 0));
		send_cmd(make_cmd(K_ERASE_FINISH, 0, 0, 0, 1023, 0, 0));
	endtask

	// page size 1 fills a block per allocate, walking a level along its list
	task automatic test_level_exhaust();
		write_ppb(0);
		run_random(400, 85);
	endtask

	task automatic test_random_mix();
		write_ppb(3);
		run_random(280, 45);
		send_idle_pct = 68;
		recv_idle_pct = 33;
		write_ppb(511);
		run_random(300, 45);
		write_ppb(1);
		run_random(300, 60);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_ppb(2);
		run_random(300, 55);
		write_ppb(256);
		run_random(350, 40);
	endtask

	initial begin
		arst_n = 0;
		cycles = 0;
		fail_count = 0;
		send_idle_pct = 33;
		recv_idle_pct = 68;
		t_now = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		in_valid = 0;
		out_stall = 0;
		kind = K_ALLOC;
		level = '0;
		for_read = 0;
		page_address = '0;
		block_id = '0;
		page_in_block = '0;
		now_time = '0;
		reset_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_level_exhaust();
		test_random_mix();
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
